[sv/cme_pkg.sv]
// cme_pkg: types, codes and helper functions for the cigar mismatch expander
// used by the channel interfaces, the result queue and the top level
package cme_pkg;

	localparam int unsigned RESULT_DEPTH = 4;

	localparam logic [1:0] KIND_ELEM = 2'd0;
	localparam logic [1:0] KIND_BASE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam logic [3:0] OP_MATCH    = 4'd0;
	localparam logic [3:0] OP_INS      = 4'd1;
	localparam logic [3:0] OP_DEL      = 4'd2;
	localparam logic [3:0] OP_SKIP     = 4'd3;
	localparam logic [3:0] OP_SOFT     = 4'd4;
	localparam logic [3:0] OP_HARD     = 4'd5;
	localparam logic [3:0] OP_MISMATCH = 4'd8;

	localparam logic [7:0] BASE_ANY   = 8'h4E;
	localparam logic [7:0] CASE_SHIFT = 8'd32;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  cigar_op;
		logic [27:0] cigar_length;
		logic [7:0]  read_base;
		logic [7:0]  ref_base;
	} item_t;

	typedef struct packed {
		logic        out_kind;
		logic [3:0]  elem_op;
		logic [27:0] elem_length;
		logic [31:0] mismatch_total;
		logic [31:0] read_offset;
		logic [31:0] ref_offset;
		logic [15:0] element_total;
		logic        bad_op;
		logic        last;
	} result_t;

	// up to two results written to the queue per transfer
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [27:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {5'd0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic [15:0] sat_inc16(input logic [15:0] a);
		return (a == '1) ? a : a + 16'd1;
	endfunction

	function automatic result_t make_elem(input logic [3:0] op, input logic [27:0] len);
		result_t r;
		r = '0;
		r.elem_op = op;
		r.elem_length = len;
		return r;
	endfunction

endpackage

[sv/cme_item_if.sv]
// cme_item_if: valid/ready channel carrying one input item
// depends on cme_pkg for the payload type
interface cme_item_if;
	logic          valid;
	logic          ready;
	cme_pkg::item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[sv/cme_result_if.sv]
// cme_result_if: valid/ready channel carrying one result item
// depends on cme_pkg for the payload type
interface cme_result_if;
	logic             valid;
	logic             ready;
	cme_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[sv/cme_result_fifo.sv]
// cme_result_fifo: small result queue taking up to two results per cycle
// depends on cme_pkg and cme_result_if
module cme_result_fifo #(
	parameter int unsigned Depth = cme_pkg::RESULT_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cme_pkg::push_t  push,
	output logic            room,
	cme_result_if.source    result
);
	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	cme_pkg::result_t  mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic [PtrW-1:0]   wr_ptr_next1;
	logic [PtrW-1:0]   wr_ptr_next2;
	logic              pop;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign wr_ptr_next1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_next2 = ptr_inc(wr_ptr_next1);
	assign pop          = result.valid & result.ready;
	assign result.valid = (count_q != '0);
	assign result.data  = mem_q[rd_ptr_q];
	assign room         = (count_q <= CntW'(Depth - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_next1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			unique case (push.count)
				2'd1:    wr_ptr_q <= wr_ptr_next1;
				2'd2:    wr_ptr_q <= wr_ptr_next2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("result queue over depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("push without room");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two results pushed");

endmodule

[sv/cigar_mismatch_expander.sv]
// cigar_mismatch_expander: turns a streamed CIGAR with its base pairs into
// an extended CIGAR with single mismatch elements; uses cme_pkg, both
// channel interfaces and cme_result_fifo
//
//  channel  dir  payload                                       items
//  item     in   kind, cigar_op, cigar_length, bases           one per transfer
//  result   out  out_kind, element, summary counters, last     0..2 per item
//
// one item enters per cycle unless stalled; it is held in the input register,
// where one compare and the counter updates are done, then its results go
// to a queue of FifoDepth entries (two or more) that drains one result per
// cycle while the result side is ready; the input stalls only while the
// queue has fewer than two free entries
// arst_n clears all counters, the input register valid and the queue
module cigar_mismatch_expander #(
	parameter int unsigned FifoDepth = cme_pkg::RESULT_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	cme_item_if.sink     item,
	cme_result_if.source result
);
	logic             valid_s1;
	cme_pkg::item_t   item_s1;
	logic             room;
	logic             advance;
	cme_pkg::push_t   push;

	logic [27:0] bases_left_q, bases_left_d;
	logic [27:0] match_run_q,  match_run_d;
	logic [31:0] mismatch_q,   mismatch_d;
	logic [31:0] read_pos_q,   read_pos_d;
	logic [31:0] ref_pos_q,    ref_pos_d;
	logic [15:0] emitted_q,    emitted_d;
	logic        stopped_q,    stopped_d;

	cme_pkg::result_t res [2];
	logic [1:0]       nres;
	logic             same;
	logic [27:0]      run_inc;
	logic [27:0]      left_dec;

	assign advance    = valid_s1 & room;
	assign item.ready = ~valid_s1 | room;

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	assign same = (item_s1.read_base == item_s1.ref_base)
		|| (item_s1.ref_base >= cme_pkg::CASE_SHIFT
			&& item_s1.read_base == item_s1.ref_base - cme_pkg::CASE_SHIFT)
		|| (item_s1.read_base == cme_pkg::BASE_ANY);
	assign run_inc  = match_run_q + 28'd1;
	assign left_dec = bases_left_q - 28'd1;

	always_comb begin
		bases_left_d = bases_left_q;
		match_run_d  = match_run_q;
		mismatch_d   = mismatch_q;
		read_pos_d   = read_pos_q;
		ref_pos_d    = ref_pos_q;
		emitted_d    = emitted_q;
		stopped_d    = stopped_q;
		res[0]       = '0;
		res[1]       = '0;
		nres         = 2'd0;

		unique case (item_s1.kind)
			cme_pkg::KIND_ELEM: begin
				if (!stopped_q) begin
					if (match_run_q != '0) begin
						res[0]    = cme_pkg::make_elem(cme_pkg::OP_MATCH, match_run_q);
						nres      = 2'd1;
						emitted_d = cme_pkg::sat_inc16(emitted_d);
					end
					match_run_d  = '0;
					bases_left_d = '0;
					unique case (item_s1.cigar_op)
						cme_pkg::OP_MATCH: begin
							bases_left_d = item_s1.cigar_length;
							read_pos_d   = cme_pkg::sat_add32(read_pos_q, item_s1.cigar_length);
							ref_pos_d    = cme_pkg::sat_add32(ref_pos_q, item_s1.cigar_length);
						end
						cme_pkg::OP_INS, cme_pkg::OP_SOFT: begin
							res[nres[0]] = cme_pkg::make_elem(item_s1.cigar_op,
								item_s1.cigar_length);
							nres         = nres + 2'd1;
							emitted_d    = cme_pkg::sat_inc16(emitted_d);
							read_pos_d   = cme_pkg::sat_add32(read_pos_q, item_s1.cigar_length);
						end
						cme_pkg::OP_DEL, cme_pkg::OP_SKIP: begin
							res[nres[0]] = cme_pkg::make_elem(item_s1.cigar_op,
								item_s1.cigar_length);
							nres         = nres + 2'd1;
							emitted_d    = cme_pkg::sat_inc16(emitted_d);
							ref_pos_d    = cme_pkg::sat_add32(ref_pos_q, item_s1.cigar_length);
						end
						cme_pkg::OP_HARD: begin
						end
						default: begin
							res[nres[0]] = cme_pkg::make_elem(item_s1.cigar_op,
								item_s1.cigar_length);
							nres         = nres + 2'd1;
							emitted_d    = cme_pkg::sat_inc16(emitted_d);
							stopped_d    = 1'b1;
						end
					endcase
				end
			end
			cme_pkg::KIND_BASE: begin
				if (!stopped_q && bases_left_q != '0) begin
					bases_left_d = left_dec;
					if (same) begin
						match_run_d = run_inc;
						if (left_dec == '0) begin
							if (run_inc != '0) begin
								res[0]    = cme_pkg::make_elem(cme_pkg::OP_MATCH, run_inc);
								nres      = 2'd1;
								emitted_d = cme_pkg::sat_inc16(emitted_d);
							end
							match_run_d = '0;
						end
					end else begin
						mismatch_d = (mismatch_q == '1) ? mismatch_q : mismatch_q + 32'd1;
						if (match_run_q != '0) begin
							res[0]    = cme_pkg::make_elem(cme_pkg::OP_MATCH, match_run_q);
							nres      = 2'd1;
							emitted_d = cme_pkg::sat_inc16(emitted_d);
						end
						match_run_d  = '0;
						res[nres[0]] = cme_pkg::make_elem(cme_pkg::OP_MISMATCH, 28'd1);
						nres         = nres + 2'd1;
						emitted_d    = cme_pkg::sat_inc16(emitted_d);
					end
				end
			end
			cme_pkg::KIND_END: begin
				if (match_run_q != '0) begin
					res[0]    = cme_pkg::make_elem(cme_pkg::OP_MATCH, match_run_q);
					nres      = 2'd1;
					emitted_d = cme_pkg::sat_inc16(emitted_d);
				end
				res[nres[0]].out_kind       = 1'b1;
				res[nres[0]].mismatch_total = mismatch_q;
				res[nres[0]].read_offset    = read_pos_q;
				res[nres[0]].ref_offset     = ref_pos_q;
				res[nres[0]].element_total  = emitted_d;
				res[nres[0]].bad_op         = stopped_q;
				nres         = nres + 2'd1;
				bases_left_d = '0;
				match_run_d  = '0;
				mismatch_d   = '0;
				read_pos_d   = '0;
				ref_pos_d    = '0;
				emitted_d    = '0;
				stopped_d    = 1'b0;
			end
			default: begin
			end
		endcase

		if (nres == 2'd1) begin
			res[0].last = 1'b1;
		end
		if (nres == 2'd2) begin
			res[1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bases_left_q <= '0;
			match_run_q  <= '0;
			mismatch_q   <= '0;
			read_pos_q   <= '0;
			ref_pos_q    <= '0;
			emitted_q    <= '0;
			stopped_q    <= 1'b0;
		end else if (advance) begin
			bases_left_q <= bases_left_d;
			match_run_q  <= match_run_d;
			mismatch_q   <= mismatch_d;
			read_pos_q   <= read_pos_d;
			ref_pos_q    <= ref_pos_d;
			emitted_q    <= emitted_d;
			stopped_q    <= stopped_d;
		end
	end

	assign push.count  = advance ? nres : 2'd0;
	assign push.first  = res[0];
	assign push.second = res[1];

	cme_result_fifo #(
		.Depth(FifoDepth)
	) u_result_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.result(result)
	);

	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (bases_left_q == '0 && match_run_q == '0))
		else $error("match state left open after bad op");

	a_run_needs_bases: assert property (@(posedge clk) disable iff (!arst_n)
		bases_left_q == '0 |-> match_run_q == '0)
		else $error("match run pending with no bases owed");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(item_s1))
		else $error("stalled item lost from input register");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == cme_pkg::KIND_END |=>
			mismatch_q == '0 && emitted_q == '0 && !stopped_q)
		else $error("state not cleared after end of read");

endmodule

[tb/sv/cigar_mismatch_expander_test.sv]
`timescale 1ns / 100ps
// cigar_mismatch_expander_test: self-checking testbench for the cigar mismatch expander,
// predicting every extended element and read summary and checking each result transfer
// depends on cme_pkg, cme_item_if, cme_result_if and cigar_mismatch_expander
module cigar_mismatch_expander_test;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [27:0] LEN_MAX = 28'hFFF_FFFF;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam string BASE_LETTERS = "ACGTacgtN";

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cme_item_if item_bus ();
	cme_result_if result_bus ();

	cigar_mismatch_expander i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus)
	);

	// predicted state of the read in progress
	logic [27:0] bases_owed;
	logic [27:0] run_len;
	logic [31:0] mismatches;
	logic [31:0] read_ofs;
	logic [31:0] ref_ofs;
	logic [15:0] elems_out;
	logic halted;

	cme_pkg::result_t expected_elems[$];
	int unsigned errors = 0;
	int unsigned items_taken = 0;
	int unsigned results_seen = 0;
	int unsigned reads_done = 0;
	int unsigned cycle_count = 0;
	bit send_gaps = 1'b1;
	bit recv_stalls = 1'b1;

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_elems.size());
			$display("cigar_mismatch_expander verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] capped_sum(input logic [31:0] a, input logic [27:0] b);
		return (a > 32'hFFFF_FFFF - {4'd0, b}) ? 32'hFFFF_FFFF : a + {4'd0, b};
	endfunction

	function automatic void clear_read_state();
		bases_owed = '0;
		run_len = '0;
		mismatches = '0;
		read_ofs = '0;
		ref_ofs = '0;
		elems_out = '0;
		halted = 1'b0;
	endfunction

	function automatic void push_elem(input logic [3:0] op, input logic [27:0] len);
		cme_pkg::result_t r;
		r = '0;
		r.elem_op = op;
		r.elem_length = len;
		expected_elems.push_back(r);
		if (elems_out != 16'hFFFF)
			elems_out++;
	endfunction

	function automatic void close_run();
		if (run_len != 0)
			push_elem(cme_pkg::OP_MATCH, run_len);
		run_len = '0;
		bases_owed = '0;
	endfunction

	// returns 0 when the item is ignored
	function automatic bit expand_item(input cme_pkg::item_t it);
		int unsigned before_n;
		bit acted;
		bit same;
		cme_pkg::result_t r;
		before_n = expected_elems.size();
		acted = 1'b1;
		case (it.kind)
			cme_pkg::KIND_ELEM: begin
				if (halted) begin
					acted = 1'b0;
				end else begin
					close_run();
					case (it.cigar_op)
						cme_pkg::OP_MATCH: begin
							bases_owed = it.cigar_length;
							read_ofs = capped_sum(read_ofs, it.cigar_length);
							ref_ofs = capped_sum(ref_ofs, it.cigar_length);
						end
						cme_pkg::OP_INS, cme_pkg::OP_SOFT: begin
							push_elem(it.cigar_op, it.cigar_length);
							read_ofs = capped_sum(read_ofs, it.cigar_length);
						end
						cme_pkg::OP_DEL, cme_pkg::OP_SKIP: begin
							push_elem(it.cigar_op, it.cigar_length);
							ref_ofs = capped_sum(ref_ofs, it.cigar_length);
						end
						cme_pkg::OP_HARD: ;
						default: begin
							push_elem(it.cigar_op, it.cigar_length);
							halted = 1'b1;
						end
					endcase
				end
			end
			cme_pkg::KIND_BASE: begin
				if (halted || bases_owed == 0) begin
					acted = 1'b0;
				end else begin
					same = (it.read_base == it.ref_base)
						|| (it.ref_base >= cme_pkg::CASE_SHIFT
							&& it.read_base == it.ref_base - cme_pkg::CASE_SHIFT)
						|| (it.read_base == cme_pkg::BASE_ANY);
					bases_owed--;
					if (same) begin
						run_len++;
						if (bases_owed == 0)
							close_run();
					end else begin
						if (mismatches != 32'hFFFF_FFFF)
							mismatches++;
						if (run_len != 0)
							push_elem(cme_pkg::OP_MATCH, run_len);
						run_len = '0;
						push_elem(cme_pkg::OP_MISMATCH, 28'd1);
					end
				end
			end
			cme_pkg::KIND_END: begin
				close_run();
				r = '0;
				r.out_kind = 1'b1;
				r.mismatch_total = mismatches;
				r.read_offset = read_ofs;
				r.ref_offset = ref_ofs;
				r.element_total = elems_out;
				r.bad_op = halted;
				expected_elems.push_back(r);
				clear_read_state();
				reads_done++;
			end
			default: acted = 1'b0;
		endcase
		if (expected_elems.size() > before_n) begin
			r = expected_elems.pop_back();
			r.last = 1'b1;
			expected_elems.push_back(r);
		end
		return acted;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		cme_pkg::result_t want;
		cme_pkg::result_t got;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			got = result_bus.data;
			if (expected_elems.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, actual %h", $time, got);
			end else begin
				want = expected_elems.pop_front();
				results_seen++;
				check_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
				check_field("elem_op", 32'(want.elem_op), 32'(got.elem_op));
				check_field("elem_length", 32'(want.elem_length), 32'(got.elem_length));
				check_field("mismatch_total", want.mismatch_total, got.mismatch_total);
				check_field("read_offset", want.read_offset, got.read_offset);
				check_field("ref_offset", want.ref_offset, got.ref_offset);
				check_field("element_total", 32'(want.element_total),
					32'(got.element_total));
				check_field("bad_op", 32'(want.bad_op), 32'(got.bad_op));
				check_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	// result side: random stall bursts
	initial begin
		result_bus.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (recv_stalls && $urandom_range(0, 5) == 0) begin
				result_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
		end
	end

	function automatic cme_pkg::item_t elem_item(input logic [3:0] op, input logic [27:0] len);
		cme_pkg::item_t it;
		it.kind = cme_pkg::KIND_ELEM;
		it.cigar_op = op;
		it.cigar_length = len;
		it.read_base = 8'($urandom);
		it.ref_base = 8'($urandom);
		return it;
	endfunction

	function automatic cme_pkg::item_t pair_item(input logic [7:0] rb, input logic [7:0] fb);
		cme_pkg::item_t it;
		it.kind = cme_pkg::KIND_BASE;
		it.cigar_op = 4'($urandom);
		it.cigar_length = 28'($urandom);
		it.read_base = rb;
		it.ref_base = fb;
		return it;
	endfunction

	function automatic cme_pkg::item_t end_item();
		cme_pkg::item_t it;
		it = pair_item(8'($urandom), 8'($urandom));
		it.kind = cme_pkg::KIND_END;
		return it;
	endfunction

	function automatic cme_pkg::item_t noise_item();
		cme_pkg::item_t it;
		it = pair_item(8'($urandom), 8'($urandom));
		it.kind = KIND_NONE;
		return it;
	endfunction

	function automatic cme_pkg::item_t random_pair();
		logic [7:0] rb;
		logic [7:0] fb;
		fb = BASE_LETTERS[$urandom_range(0, 8)];
		case ($urandom_range(0, 9))
			0, 1, 2, 3: rb = fb;
			4, 5: rb = (fb >= "a") ? fb - cme_pkg::CASE_SHIFT : fb;
			6: rb = cme_pkg::BASE_ANY;
			7, 8: rb = BASE_LETTERS[$urandom_range(0, 8)];
			default: begin
				rb = 8'($urandom);
				fb = 8'($urandom);
			end
		endcase
		return pair_item(rb, fb);
	endfunction

	task automatic send_item(input cme_pkg::item_t it);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.data <= it;
		do @(posedge clk); while (!item_bus.ready);
		if (expand_item(it))
			items_taken++;
	endtask

	task automatic wait_for_results();
		item_bus.valid <= 1'b0;
		while (expected_elems.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mixed ops, case-insensitive reference, N in the read, back-to-back mismatches
	task automatic test_basic_read();
		send_item(elem_item(cme_pkg::OP_SOFT, 28'd3));
		send_item(elem_item(cme_pkg::OP_HARD, 28'd2));
		send_item(elem_item(cme_pkg::OP_MATCH, 28'd6));
		send_item(pair_item("A", "A"));
		send_item(pair_item("C", "c"));
		send_item(pair_item("N", "G"));
		send_item(pair_item("A", "T"));
		// upper-casing must not wrap below zero
		send_item(pair_item(8'hF0, 8'h10));
		send_item(pair_item("g", "g"));
		send_item(elem_item(cme_pkg::OP_INS, 28'd0));
		send_item(elem_item(cme_pkg::OP_DEL, LEN_MAX));
		send_item(elem_item(cme_pkg::OP_SKIP, 28'd1));
		send_item(elem_item(cme_pkg::OP_MATCH, 28'd0));
		send_item(end_item());
		wait_for_results();
	endtask

	// abandoned match bases, end mid element, stray pairs and unused kinds
	task automatic test_truncated_match();
		send_item(elem_item(cme_pkg::OP_MATCH, 28'd5));
		send_item(pair_item("A", "A"));
		send_item(pair_item("t", "T"));
		send_item(elem_item(cme_pkg::OP_DEL, 28'd1));
		send_item(elem_item(cme_pkg::OP_MATCH, 28'd4));
		send_item(pair_item("C", "C"));
		send_item(end_item());
		send_item(pair_item("A", "A"));
		send_item(noise_item());
		wait_for_results();
	endtask

	task automatic test_bad_op();
		send_item(elem_item(cme_pkg::OP_MATCH, 28'd3));
		send_item(pair_item("G", "g"));
		send_item(elem_item(4'd15, LEN_MAX));
		send_item(elem_item(cme_pkg::OP_INS, 28'd4));
		send_item(pair_item("A", "T"));
		send_item(end_item());
		wait_for_results();
	endtask

	task automatic test_offset_saturation();
		repeat (17) send_item(elem_item(cme_pkg::OP_DEL, LEN_MAX));
		repeat (17) send_item(elem_item(cme_pkg::OP_SOFT, LEN_MAX));
		send_item(elem_item(cme_pkg::OP_MATCH, LEN_MAX));
		send_item(pair_item("T", "A"));
		send_item(end_item());
		wait_for_results();
	endtask

	// alternating match and mismatch, two results per mismatching pair
	task automatic test_dense_mismatches();
		send_item(elem_item(cme_pkg::OP_MATCH, 28'd40));
		repeat (20) begin
			send_item(pair_item("C", "C"));
			send_item(pair_item("C", "G"));
		end
		send_item(end_item());
		wait_for_results();
	endtask

	// whole reads with random content, some truncated, some with noise
	task automatic test_random_reads(input int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned len;
		int unsigned n_bases;
		stop_at = items_taken + quota;
		while (items_taken < stop_at) begin
			repeat ($urandom_range(1, 6)) begin
				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 15) == 0)
					len = $urandom & LEN_MAX;
				else
					len = $urandom_range(0, 8);
				if (pick < 50) begin
					send_item(elem_item(cme_pkg::OP_MATCH, 28'(len)));
					n_bases = (len > 8) ? $urandom_range(0, 4) : len;
					case ($urandom_range(0, 9))
						0: n_bases = $urandom_range(0, n_bases);
						1: n_bases += $urandom_range(1, 2);
						default: ;
					endcase
					repeat (n_bases) send_item(random_pair());
				end else if (pick < 62) begin
					send_item(elem_item(pick[0] ? cme_pkg::OP_INS : cme_pkg::OP_SOFT,
						28'(len)));
				end else if (pick < 74) begin
					send_item(elem_item(pick[0] ? cme_pkg::OP_DEL : cme_pkg::OP_SKIP,
						28'(len)));
				end else if (pick < 84) begin
					send_item(elem_item(cme_pkg::OP_HARD, 28'(len)));
				end else if (pick < 88) begin
					send_item(elem_item(4'($urandom_range(6, 15)), 28'(len)));
				end else if (pick < 94) begin
					send_item(random_pair());
				end else begin
					send_item(noise_item());
				end
			end
			send_item(end_item());
			if ($urandom_range(0, 29) == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	initial begin
		clear_read_state();
		item_bus.valid = 1'b0;
		item_bus.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_read();
		test_truncated_match();
		test_bad_op();
		test_offset_saturation();
		test_random_reads(75);
		send_gaps = 1'b1;
		recv_stalls = 1'b0;
		test_random_reads(65);
		send_gaps = 1'b0;
		recv_stalls = 1'b1;
		test_random_reads(65);
		recv_stalls = 1'b0;
		test_dense_mismatches();
		test_random_reads(65);

		wait_for_results();
		repeat (10) @(posedge clk);
		if (expected_elems.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, expected_elems.size());
		end
		$display("covered %0d effective items over %0d reads, %0d results compared",
			items_taken, reads_done, results_seen);
		$display("incl. mismatch splits, abandoned matches, bad ops and offset saturation");
		if (errors == 0) begin
			$display("cigar_mismatch_expander verification clean");
		end else begin
			$display("cigar_mismatch_expander verification failed");
		end
		$finish;
	end
endmodule
